### rtl/mf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf_pkg
// Shared types, constants and compare helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf_pkg;

    // Default frame limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_SIZE       = 3;

    // Field widths
    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;

    // Result queue depth (covers the pipeline so the input stalls only when the output holds back results)
    localparam int FIFO_DEPTH = 8;

    // Configuration register map
    localparam int   CFG_IDX_W        = 1;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    typedef logic [PIX_W-1:0]      t_pix;
    typedef logic [2:0][PIX_W-1:0] t_trio;   // [0] low, [1] middle, [2] high
    typedef logic [8:0][PIX_W-1:0] t_win;    // row-major 3x3 window

    // Position information that travels with a pixel
    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } t_tag;

    // One result item
    typedef struct packed {
        t_pix             median;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } t_res;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_trio sort3(input t_pix a, input t_pix b, input t_pix c);
        t_trio s;
        s[0] = min2(min2(a, b), c);
        s[1] = med3(a, b, c);
        s[2] = max2(max2(a, b), c);
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/mf_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf_pix_if
// Valid/ready channel carrying one grey pixel per transaction.
// ----------------------------------------------------------------------------
interface mf_pix_if import mf_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

### rtl/mf_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf_res_if
// Valid/ready channel carrying one filtered pixel with its position.
// ----------------------------------------------------------------------------
interface mf_res_if import mf_pkg::*; ();
    logic             valid;
    logic             ready;
    t_pix             median_value;
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
    logic             frame_done;

    modport source (output valid, output median_value, output centre_row,
                    output centre_col, output frame_done, input ready);
    modport sink   (input valid, input median_value, input centre_row,
                    input centre_col, input frame_done, output ready);
endinterface
`default_nettype wire

### rtl/median_filter_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// The pixel that completes a 3x3 neighborhood passes the line RAM read, the
// window, three compare stages and the result queue before its result is valid.
// Throughput: one pixel per cycle; the line RAM reads one column while writing
// back the previous one, and input stalls only with FIFO_DEPTH results pending.
// Reset (synchronous, active low) clears the position counters, the pipeline and
// the result queue and restores 640x480; line RAM contents are kept.
// ----------------------------------------------------------------------------
// median_filter_3x3
// Raster-order 3x3 median filter with configurable frame size.
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    mf_pix_if.sink                    i_pix,
    mf_res_if.source                  o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CSW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int RSW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
    localparam int CXW = (CW > POS_W) ? CW : POS_W;
    localparam int RXW = (RW > POS_W) ? RW : POS_W;
    localparam int PW  = $clog2(FIFO_DEPTH + 1);

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [PW-1:0]    r_pending;

    logic [CSW-1:0] width_eff;
    logic [RSW-1:0] height_eff;
    logic           last_col;
    logic           last_row;
    logic           in_fire;
    logic           out_fire;
    logic [CXW-1:0] col_m1;
    logic [RXW-1:0] row_m1;
    t_tag           in_tag;

    logic win_valid;
    t_win win;
    t_tag win_tag;
    logic med_valid;
    t_pix med_value;
    t_tag med_tag;
    t_res push_data;
    logic fifo_valid;
    t_res fifo_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the frame size to the supported range
    always_comb begin
        width_eff = CSW'(r_cfg_width);
        if (width_eff < CSW'(MIN_SIZE)) begin
            width_eff = CSW'(MIN_SIZE);
        end else if (width_eff > CSW'(MAX_WIDTH)) begin
            width_eff = CSW'(MAX_WIDTH);
        end
        height_eff = RSW'(r_cfg_height);
        if (height_eff < RSW'(MIN_SIZE)) begin
            height_eff = RSW'(MIN_SIZE);
        end else if (height_eff > RSW'(MAX_HEIGHT)) begin
            height_eff = RSW'(MAX_HEIGHT);
        end
    end

    // Position of the incoming pixel
    assign last_col = (CSW'(r_col) + CSW'(1)) >= width_eff;
    assign last_row = (RSW'(r_row) + RSW'(1)) >= height_eff;
    assign col_m1   = CXW'(r_col) - CXW'(1);
    assign row_m1   = RXW'(r_row) - RXW'(1);

    always_comb begin
        in_tag.emit = (r_row >= RW'(2)) && (r_col >= CW'(2));
        in_tag.row  = row_m1[POS_W-1:0];
        in_tag.col  = col_m1[POS_W-1:0];
        in_tag.done = last_col && last_row;
    end

    // Accept while every outstanding result has a queue slot
    assign i_pix.ready = (r_pending < PW'(FIFO_DEPTH));
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign out_fire    = fifo_valid && o_res.ready;

    // Advance the raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Count results in flight or queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            if ((in_fire && in_tag.emit) && !out_fire) begin
                r_pending <= r_pending + 1'b1;
            end else if (!(in_fire && in_tag.emit) && out_fire) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    mf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (CW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_fire),
        .i_pixel (i_pix.pixel),
        .i_addr  (r_col),
        .i_tag   (in_tag),
        .o_valid (win_valid),
        .o_win   (win),
        .o_tag   (win_tag)
    );

    mf_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (win_valid),
        .i_win    (win),
        .i_tag    (win_tag),
        .o_valid  (med_valid),
        .o_median (med_value),
        .o_tag    (med_tag)
    );

    always_comb begin
        push_data.median = med_value;
        push_data.row    = med_tag.row;
        push_data.col    = med_tag.col;
        push_data.done   = med_tag.done;
    end

    mf_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (med_valid && med_tag.emit),
        .i_data  (push_data),
        .i_pop   (o_res.ready),
        .o_valid (fifo_valid),
        .o_data  (fifo_data)
    );

    // Drive the result channel
    assign o_res.valid        = fifo_valid;
    assign o_res.median_value = fifo_data.median;
    assign o_res.centre_row   = fifo_data.row;
    assign o_res.centre_col   = fifo_data.col;
    assign o_res.frame_done   = fifo_data.done;

endmodule
`default_nettype wire

### rtl/mf_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf_line_buf
// Two line stores packed in one synchronous RAM plus the 3x3 window.
// Each entry holds {upper row, middle row} of one column; a pixel reads its
// column, then writes back {old middle, new pixel} in the next cycle.
// ----------------------------------------------------------------------------
module mf_line_buf import mf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_pix              i_pixel,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire t_tag              i_tag,
    output logic                   o_valid,
    output t_win                   o_win,
    output t_tag                   o_tag
);

    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;

    logic              r_s1_valid;
    t_pix              r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;
    t_tag              r_s1_tag;

    logic r_win_valid;
    t_win r_win;
    t_tag r_win_tag;

    // Read the column on accept, write it back the next cycle. The same column
    // is revisited at least three transactions later, so no forwarding needed.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd_data <= r_line_mem[i_addr];
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_addr] <= {r_rd_data[PIX_W-1:0], r_s1_pix};
        end
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_win_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_win_valid <= r_s1_valid;
        end
    end

    // Hold the pixel and tag alongside the read
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_pix  <= i_pixel;
            r_s1_addr <= i_addr;
            r_s1_tag  <= i_tag;
        end
    end

    // Shift the window left and load the new column
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3+0] <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2]  <= r_rd_data[2*PIX_W-1:PIX_W];
            r_win[5]  <= r_rd_data[PIX_W-1:0];
            r_win[8]  <= r_s1_pix;
            r_win_tag <= r_s1_tag;
        end
    end

    assign o_valid = r_win_valid;
    assign o_win   = r_win;
    assign o_tag   = r_win_tag;

endmodule
`default_nettype wire

### rtl/mf_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf_median
// Three-stage median-of-nine network: sort each row, then take the max of
// the lows, the median of the middles and the min of the highs, then the
// median of those three.
// ----------------------------------------------------------------------------
module mf_median import mf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_win i_win,
    input  wire t_tag i_tag,
    output logic      o_valid,
    output t_pix      o_median,
    output t_tag      o_tag
);

    logic            r_a_valid;
    t_trio [2:0]     r_a_rows;
    t_tag            r_a_tag;

    logic r_b_valid;
    t_pix r_b_lo;
    t_pix r_b_mid;
    t_pix r_b_hi;
    t_tag r_b_tag;

    logic r_c_valid;
    t_pix r_c_med;
    t_tag r_c_tag;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Sort each window row
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_a_rows[k] <= sort3(i_win[k*3+0], i_win[k*3+1], i_win[k*3+2]);
        end
        r_a_tag <= i_tag;
    end

    // Combine across rows
    always_ff @(posedge i_clk) begin
        r_b_lo  <= max2(max2(r_a_rows[0][0], r_a_rows[1][0]), r_a_rows[2][0]);
        r_b_mid <= med3(r_a_rows[0][1], r_a_rows[1][1], r_a_rows[2][1]);
        r_b_hi  <= min2(min2(r_a_rows[0][2], r_a_rows[1][2]), r_a_rows[2][2]);
        r_b_tag <= r_a_tag;
    end

    // Final median
    always_ff @(posedge i_clk) begin
        r_c_med <= med3(r_b_lo, r_b_mid, r_b_hi);
        r_c_tag <= r_b_tag;
    end

    assign o_valid  = r_c_valid;
    assign o_median = r_c_med;
    assign o_tag    = r_c_tag;

endmodule
`default_nettype wire

### rtl/mf_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf_out_fifo
// Small result queue between the filter pipeline and the output channel.
// ----------------------------------------------------------------------------
module mf_out_fifo import mf_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_data,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_res      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_res            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            pop;

    assign pop = i_pop && (r_count != '0);

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

### tb/mf_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_result_checker
// Watches the pixel, result and register ports of the 3x3 median filter. It
// keeps its own model of the line stores, the window and the raster position,
// predicts one filtered pixel for every interior position, and compares each
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mf_result_checker import mf_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    mf_pix_if                         i_pix,
    mf_res_if                         i_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_result_count,
    output int                        o_frame_count,
    output int                        o_frame_left
);

    localparam int LINE_DEPTH   = MAX_WIDTH_DEF;
    localparam int WIN_SIZE     = 9;
    localparam int MID_RANK     = 4;
    localparam int REPORT_LIMIT = 10;

    logic [CFG_W-1:0] width_cfg;
    logic [CFG_W-1:0] height_cfg;
    t_pix             upper_row [LINE_DEPTH];
    t_pix             middle_row [LINE_DEPTH];
    t_win             window;
    int               col_pos;
    int               row_pos;
    t_res             median_q [$];

    // Map a register value onto the frame size the block really uses
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int top_val);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > top_val) return top_val;
        return int'(v);
    endfunction

    // Pick the value with at most four smaller cells and at least five not larger
    function automatic t_pix median_of_window(input t_win w);
        int below;
        int not_above;
        for (int i = 0; i < WIN_SIZE; i++) begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < WIN_SIZE; j++) begin
                if (w[j] < w[i]) below++;
                if (w[j] <= w[i]) not_above++;
            end
            if (below <= MID_RANK && not_above > MID_RANK) return w[i];
        end
        return w[0];
    endfunction

    // Advance the model by one pixel and queue the filtered pixel it completes
    task automatic filter_pixel(input t_pix p);
        int   w;
        int   h;
        int   ci;
        logic last_col;
        logic last_row;
        t_res item;
        w = clamp_dim(width_cfg, MAX_WIDTH_DEF);
        h = clamp_dim(height_cfg, MAX_HEIGHT_DEF);
        ci = col_pos % LINE_DEPTH;
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);

        // Shift the window left and load the new column
        for (int k = 0; k < 3; k++) begin
            window[3*k]   = window[3*k+1];
            window[3*k+1] = window[3*k+2];
        end
        window[2] = upper_row[ci];
        window[5] = middle_row[ci];
        window[8] = p;
        upper_row[ci]  = middle_row[ci];
        middle_row[ci] = p;

        if (row_pos >= 2 && col_pos >= 2) begin
            item.median = median_of_window(window);
            item.row    = POS_W'(row_pos - 1);
            item.col    = POS_W'(col_pos - 1);
            item.done   = last_col && last_row;
            median_q.push_back(item);
        end

        // Wrap the position at the last column and at the last row
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
    endtask

    // Compare one result transaction with the oldest prediction
    task automatic check_result();
        t_res want;
        o_result_count++;
        if (i_res.frame_done === 1'b1) o_frame_count++;
        if (median_q.size() == 0) begin
            note_failure($sformatf(
                "unexpected result: median %0d row %0d col %0d done %0b",
                i_res.median_value, i_res.centre_row, i_res.centre_col, i_res.frame_done));
        end else begin
            want = median_q.pop_front();
            if (i_res.median_value !== want.median || i_res.centre_row !== want.row ||
                i_res.centre_col !== want.col || i_res.frame_done !== want.done) begin
                note_failure($sformatf(
                    "result %0d: expected median %0d row %0d col %0d done %0b, got %0d %0d %0d %0b",
                    o_result_count, want.median, want.row, want.col, want.done,
                    i_res.median_value, i_res.centre_row, i_res.centre_col,
                    i_res.frame_done));
            end
        end
    endtask

    // Pixels still needed to reach the end of the current frame
    function automatic int pixels_to_frame_end();
        int w;
        int h;
        w = clamp_dim(width_cfg, MAX_WIDTH_DEF);
        h = clamp_dim(height_cfg, MAX_HEIGHT_DEF);
        return ((col_pos + 1 >= w) ? 1 : w - col_pos) +
               ((row_pos + 1 >= h) ? 0 : (h - 1 - row_pos) * w);
    endfunction

    // Track register writes and both channels at every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_cfg      = WIDTH_RST;
            height_cfg     = HEIGHT_RST;
            window         = '0;
            col_pos        = 0;
            row_pos        = 0;
            median_q.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_frame_count  = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WIDTH) width_cfg = i_cfg_data;
                else height_cfg = i_cfg_data;
            end
            if (i_pix.valid && i_pix.ready) filter_pixel(i_pix.pixel);
            if (i_res.valid && i_res.ready) check_result();
        end
        o_pending    = median_q.size();
        o_frame_left = pixels_to_frame_end();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 3x3 median filter. A few hand-made 3x3 frames
// come first, then a back-pressure frame, a row at the clamped widest width,
// and random frame sizes with sizes changed mid-frame, under random idling
// on both channels. The checker beside the block does the prediction.
// ----------------------------------------------------------------------------
module tb;
    import mf_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 3;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int ITEM_TARGET      = 1300;
    localparam int MAX_GAP          = 5;
    localparam int SETTLE_CYCLES    = 10;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int FRAME_RUN_MAX    = 400;
    localparam int BP_WIDTH         = 16;
    localparam int BP_HEIGHT        = 4;
    localparam int WIDE_TAIL_WIDTH  = 5;

    typedef enum int {PIX_UNIFORM, PIX_IMPULSE, PIX_FLAT, PIX_FEW} pix_style_e;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int frame_count;
    int frame_left;
    int cycle_count;
    int items_sent;
    int reg_writes;
    int hold_asked;
    int hold_served;
    t_pix flat_base;

    mf_pix_if pix_bus ();
    mf_res_if res_bus ();

    median_filter_3x3 dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mf_result_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_pix          (pix_bus),
        .i_res          (res_bus),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_frame_count  (frame_count),
        .o_frame_left   (frame_left)
    );

    // Clock
    always begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_pix draw_pixel(input pix_style_e style);
        case (style)
            PIX_IMPULSE: begin
                case ($urandom_range(0, 4))
                    0, 1: return 8'h00;
                    2, 3: return 8'hFF;
                    default: return t_pix'($urandom_range(0, 255));
                endcase
            end
            PIX_FLAT: return flat_base + t_pix'($urandom_range(0, 3));
            PIX_FEW: return t_pix'($urandom_range(0, 2) * 127);
            default: return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    // Widths stay within the columns that the back-pressure frame has filled
    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 5))
            0: return CFG_W'($urandom_range(0, MIN_SIZE - 1));
            default: return CFG_W'($urandom_range(MIN_SIZE, BP_WIDTH));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        case ($urandom_range(0, 11))
            0: return CFG_W'($urandom_range(0, MIN_SIZE - 1));
            1: return CFG_W'($urandom_range(MAX_HEIGHT_DEF + 1, 2047));
            2: return CFG_W'(MAX_HEIGHT_DEF);
            default: return CFG_W'($urandom_range(MIN_SIZE, 8));
        endcase
    endfunction

    // Offer one pixel after an idle gap and hold it until the transaction
    task automatic push_pixel(input t_pix p, input int gap);
        if (gap > 0) begin
            pix_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_bus.valid = 1'b1;
        pix_bus.pixel = p;
        @(posedge clk);
        while (!pix_bus.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_run(input int count, input pix_style_e style, input bit gaps_on);
        flat_base = t_pix'($urandom_range(0, 255));
        for (int n = 0; n < count; n++) begin
            push_pixel(draw_pixel(style), gaps_on ? $urandom_range(0, MAX_GAP) : 0);
        end
        pix_bus.valid = 1'b0;
    endtask

    // Send a 3x3 window in raster order
    task automatic send_window(input t_win w, input bit gaps_on);
        for (int n = 0; n < 9; n++) begin
            push_pixel(w[n], gaps_on ? $urandom_range(0, MAX_GAP) : 0);
        end
        pix_bus.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        reg_writes++;
    endtask

    // Hold until every predicted result is out and the pipeline has emptied
    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls, calm stretches, and a long hold on request
    initial begin : result_sink
        int stall;
        int burst_left;
        bit calm;
        burst_left = 0;
        calm = 1'b0;
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_served < hold_asked) begin
                res_bus.ready = 1'b0;
                for (int k = 0; k < LONG_HOLD_CYCLES; k++) @(negedge clk);
                hold_served++;
            end
            if (burst_left == 0) begin
                calm = ($urandom_range(0, 2) == 0);
                burst_left = $urandom_range(20, 60);
            end
            burst_left--;
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                res_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_bus.ready = 1'b1;
            @(posedge clk);
            while (!res_bus.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        t_win       shape;
        pix_style_e style;
        int         count;

        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: sizes below minimum act as 3x3
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        // dark centre among bright pixels is dropped
        shape = {9{8'hFF}};
        shape[4] = 8'h00;
        send_window(shape, 1'b1);
        // two bright pixels in a dark field are dropped
        shape = '0;
        shape[4] = 8'hFF;
        shape[8] = 8'hFF;
        send_window(shape, 1'b0);
        // one bit per pixel: every input bit toggles
        for (int n = 0; n < 8; n++) shape[n] = t_pix'(1 << n);
        shape[8] = 8'hFF;
        send_window(shape, 1'b0);
        wait_idle();

        // Back-pressure: stream a full frame while the result side holds off
        write_reg(REG_FRAME_WIDTH, CFG_W'(BP_WIDTH));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(BP_HEIGHT));
        hold_asked++;
        send_run(frame_left, PIX_FLAT, 1'b0);
        wait_idle();

        // Widest row: above-maximum width clamps to 1024, then narrow mid-frame
        write_reg(REG_FRAME_WIDTH, 11'd2047);
        write_reg(REG_FRAME_HEIGHT, 11'd0);
        send_run(MAX_WIDTH_DEF, PIX_UNIFORM, 1'b1);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(WIDE_TAIL_WIDTH));
        send_run(frame_left, PIX_IMPULSE, 1'b0);
        wait_idle();

        // Random sizes; runs that stop mid-frame leave the next size change mid-frame
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, pick_width());
            if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, pick_height());
            style = pix_style_e'($urandom_range(0, 3));
            if (frame_left <= FRAME_RUN_MAX && $urandom_range(0, 2) != 0) count = frame_left;
            else count = $urandom_range(1, 40);
            send_run(count, style, $urandom_range(0, 3) != 0);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d pixels across %0d register writes, sizes from below 3 to above 1024",
                 items_sent, reg_writes);
        $display("Checked %0d filtered pixels, %0d of them closing a frame",
                 result_count, frame_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/mf_pkg.sv
rtl/mf_pix_if.sv
rtl/mf_res_if.sv
rtl/mf_line_buf.sv
rtl/mf_median.sv
rtl/mf_out_fifo.sv
rtl/median_filter_3x3.sv
tb/mf_result_checker.sv
tb/tb.sv
